@@ hdl/touch_swipe_detector_macros.svh @@
// Assertion macros shared by the RTL of the touch swipe detector.
// Every check samples on the rising edge of clk and is held off during reset.
`ifndef TOUCH_SWIPE_DETECTOR_MACROS_SVH
`define TOUCH_SWIPE_DETECTOR_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define TSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch_swipe_detector: same-cycle check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define TSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch_swipe_detector: next-cycle check failed");

`endif

@@ hdl/tsd_pkg.sv @@
`default_nettype none

package tsd_pkg;

  // Widths of the event and result fields.
  localparam int FIELD_WIDTH   = 16;
  localparam int GESTURE_WIDTH = 3;

  // Default coordinate width held in the position registers.
  localparam int COORD_WIDTH_DEF = 16;

  // Event types and codes.
  localparam logic [FIELD_WIDTH-1:0] EVT_KEY   = 16'd1;
  localparam logic [FIELD_WIDTH-1:0] EVT_ABS   = 16'd3;
  localparam logic [FIELD_WIDTH-1:0] AXIS_X    = 16'd0;
  localparam logic [FIELD_WIDTH-1:0] AXIS_Y    = 16'd1;
  localparam logic [FIELD_WIDTH-1:0] KEY_TOUCH = 16'd330;

  // Threshold register value after reset.
  localparam logic [FIELD_WIDTH-1:0] THRESHOLD_RESET = 16'd60;

  // Swipe direction codes.
  typedef enum logic [GESTURE_WIDTH-1:0] {
    G_NONE  = 3'd0,
    G_RIGHT = 3'd1,
    G_LEFT  = 3'd2,
    G_DOWN  = 3'd3,
    G_UP    = 3'd4
  } gesture_t;

endpackage

`default_nettype wire

@@ hdl/touch_swipe_detector.sv @@
// A release beat accepted on the event channel passes through the input register, then the
// result register, and is presented on the out_ ports from there.
// Throughput: one event beat per cycle while in_stall is low. A release waits in the input
// register while the result register holds an untaken beat, and the input stalls behind it.
// Reset (rst_n low, synchronous): threshold returns to 60, position, start point and
// pending X clear, the axis history is emptied and both pipeline stages drain.
`default_nettype none

`include "touch_swipe_detector_macros.svh"

module touch_swipe_detector
  import tsd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration port
  input  wire logic                     cfg_wr_en,
  input  wire logic [FIELD_WIDTH-1:0]   cfg_wr_data,
  // Event channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [FIELD_WIDTH-1:0]   in_event_type,
  input  wire logic [FIELD_WIDTH-1:0]   in_event_code,
  input  wire logic [FIELD_WIDTH-1:0]   in_event_value,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [GESTURE_WIDTH-1:0]      out_gesture,
  output logic [FIELD_WIDTH-1:0]        out_start_x,
  output logic [FIELD_WIDTH-1:0]        out_start_y,
  output logic [FIELD_WIDTH-1:0]        out_end_x,
  output logic [FIELD_WIDTH-1:0]        out_end_y
);

  // Width of a displacement magnitude, wide enough to compare with the threshold.
  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = (DW > FIELD_WIDTH) ? DW : FIELD_WIDTH;

  // Threshold register.
  logic [FIELD_WIDTH-1:0] threshold_r;

  // Input register stage.
  logic                   s1_valid_r;
  logic [FIELD_WIDTH-1:0] s1_type_r;
  logic [FIELD_WIDTH-1:0] s1_code_r;
  logic [FIELD_WIDTH-1:0] s1_value_r;

  // Tracking state.
  logic                   prev_x_r,   prev_x_nxt;
  logic [COORD_WIDTH-1:0] pending_x_r, pending_x_nxt;
  logic [COORD_WIDTH-1:0] cur_x_r,    cur_x_nxt;
  logic [COORD_WIDTH-1:0] cur_y_r,    cur_y_nxt;
  logic [COORD_WIDTH-1:0] first_x_r,  first_x_nxt;
  logic [COORD_WIDTH-1:0] first_y_r,  first_y_nxt;
  logic                   first_captured_r, first_captured_nxt;

  // Result register.
  logic                   out_valid_r;
  gesture_t               gesture_r;
  logic [FIELD_WIDTH-1:0] start_x_r, start_y_r, end_x_r, end_y_r;

  // Decode and classification.
  logic                   s1_abs;
  logic                   s1_release;
  logic                   s1_advance;
  logic                   out_free;
  logic [COORD_WIDTH-1:0] s1_coord;
  logic [DW-1:0]          dx, dy;
  logic [DW-1:0]          ax_raw, ay_raw;
  logic [MW-1:0]          ax, ay, thr;
  logic                   dx_pos, dy_pos;
  gesture_t               gesture_c;

  // Handshake: the result slot frees when empty or when its beat is taken.
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_abs     = (s1_type_r == EVT_ABS);
  assign s1_release = (s1_type_r == EVT_KEY) && (s1_code_r == KEY_TOUCH) &&
                      (s1_value_r == '0);
  assign s1_advance = s1_valid_r && (!s1_release || out_free);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign s1_coord   = COORD_WIDTH'(s1_value_r);

  // Displacement from start point to current position and swipe direction.
  always_comb begin
    dx     = {1'b0, cur_x_r} - {1'b0, first_x_r};
    dy     = {1'b0, cur_y_r} - {1'b0, first_y_r};
    ax_raw = dx[DW-1] ? (-dx) : dx;
    ay_raw = dy[DW-1] ? (-dy) : dy;
    ax     = MW'(ax_raw);
    ay     = MW'(ay_raw);
    thr    = MW'(threshold_r);
    dx_pos = !dx[DW-1] && (dx != '0);
    dy_pos = !dy[DW-1] && (dy != '0);
    priority if (ax < thr && ay < thr) begin
      gesture_c = G_NONE;
    end else if (ax > ay) begin
      gesture_c = dx_pos ? G_RIGHT : G_LEFT;
    end else begin
      gesture_c = dy_pos ? G_DOWN : G_UP;
    end
  end

  // Next tracking state for the event in the input register.
  always_comb begin
    prev_x_nxt         = prev_x_r;
    pending_x_nxt      = pending_x_r;
    cur_x_nxt          = cur_x_r;
    cur_y_nxt          = cur_y_r;
    first_x_nxt        = first_x_r;
    first_y_nxt        = first_y_r;
    first_captured_nxt = first_captured_r;
    if (s1_advance && s1_abs) begin
      prev_x_nxt = (s1_code_r == AXIS_X);
      if (s1_code_r == AXIS_X) begin
        pending_x_nxt = s1_coord;
      end
      // An X event followed by a Y event, with no other axis event between, forms a coordinate pair.
      if (prev_x_r && s1_code_r == AXIS_Y) begin
        cur_x_nxt = pending_x_r;
        cur_y_nxt = s1_coord;
        if (!first_captured_r) begin
          first_captured_nxt = 1'b1;
          first_x_nxt        = pending_x_r;
          first_y_nxt        = s1_coord;
        end
      end
    end else if (s1_advance && s1_release) begin
      prev_x_nxt         = 1'b0;
      pending_x_nxt      = '0;
      first_x_nxt        = '0;
      first_y_nxt        = '0;
      first_captured_nxt = 1'b0;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Input register: takes a beat whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_type_r  <= in_event_type;
      s1_code_r  <= in_event_code;
      s1_value_r <= in_event_value;
    end
  end

  // Tracking state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r         <= 1'b0;
      pending_x_r      <= '0;
      cur_x_r          <= '0;
      cur_y_r          <= '0;
      first_x_r        <= '0;
      first_y_r        <= '0;
      first_captured_r <= 1'b0;
    end else begin
      prev_x_r         <= prev_x_nxt;
      pending_x_r      <= pending_x_nxt;
      cur_x_r          <= cur_x_nxt;
      cur_y_r          <= cur_y_nxt;
      first_x_r        <= first_x_nxt;
      first_y_r        <= first_y_nxt;
      first_captured_r <= first_captured_nxt;
    end
  end

  // Result register: loaded on a release, cleared once its beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_release) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_release) begin
      gesture_r <= gesture_c;
      start_x_r <= FIELD_WIDTH'(first_x_r);
      start_y_r <= FIELD_WIDTH'(first_y_r);
      end_x_r   <= FIELD_WIDTH'(cur_x_r);
      end_y_r   <= FIELD_WIDTH'(cur_y_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_gesture = gesture_r;
  assign out_start_x = start_x_r;
  assign out_start_y = start_y_r;
  assign out_end_x   = end_x_r;
  assign out_end_y   = end_y_r;

  // A release that leaves the input register always shows up as a result beat.
  `TSD_ASSERT_NEXT(a_release_gives_result, s1_advance && s1_release, out_valid_r)
  // A release empties the press state and the axis history.
  `TSD_ASSERT_NEXT(a_release_clears_press, s1_advance && s1_release,
                   !prev_x_r && !first_captured_r && pending_x_r == '0)
  // Without a captured start point the start point stays at zero.
  `TSD_ASSERT_SAME(a_start_zero_until_captured, !first_captured_r,
                   first_x_r == '0 && first_y_r == '0)
  // Stall is raised only for a release held by a full result slot.
  `TSD_ASSERT_SAME(a_stall_only_on_blocked_release, in_stall,
                   s1_valid_r && s1_release && out_valid_r && out_stall)

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tsd_pkg::*;

  // Axis history value after reset and after each release.
  localparam logic [FIELD_WIDTH-1:0] NO_AXIS_CODE = 16'd10;
  // Receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] ev_type;
    logic [FIELD_WIDTH-1:0] ev_code;
    logic [FIELD_WIDTH-1:0] ev_value;
  } touch_evt_t;

  typedef struct packed {
    gesture_t               gesture;
    logic [FIELD_WIDTH-1:0] start_x;
    logic [FIELD_WIDTH-1:0] start_y;
    logic [FIELD_WIDTH-1:0] end_x;
    logic [FIELD_WIDTH-1:0] end_y;
  } swipe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [FIELD_WIDTH-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_WIDTH-1:0] in_event_type = '0;
  logic [FIELD_WIDTH-1:0] in_event_code = '0;
  logic [FIELD_WIDTH-1:0] in_event_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [GESTURE_WIDTH-1:0] out_gesture;
  logic [FIELD_WIDTH-1:0] out_start_x;
  logic [FIELD_WIDTH-1:0] out_start_y;
  logic [FIELD_WIDTH-1:0] out_end_x;
  logic [FIELD_WIDTH-1:0] out_end_y;

  touch_swipe_detector uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_event_type  (in_event_type),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gesture    (out_gesture),
    .out_start_x    (out_start_x),
    .out_start_y    (out_start_y),
    .out_end_x      (out_end_x),
    .out_end_y      (out_end_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Events waiting to be sent and swipes the block still owes us.
  touch_evt_t touch_q[$];
  swipe_t     swipes_due[$];

  // Tracked touch state, mirrored from the block's behavior.
  logic [FIELD_WIDTH-1:0] sw_thr = THRESHOLD_RESET;
  logic [FIELD_WIDTH-1:0] last_axis = NO_AXIS_CODE;
  logic [FIELD_WIDTH-1:0] held_x = '0;
  logic [FIELD_WIDTH-1:0] pos_x = '0;
  logic [FIELD_WIDTH-1:0] pos_y = '0;
  logic [FIELD_WIDTH-1:0] org_x = '0;
  logic [FIELD_WIDTH-1:0] org_y = '0;
  logic                   org_valid = 1'b0;

  int idle_mode = 1;
  int hold_asked = 0;
  int hold_taken = 0;
  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;
  int quiet = 0;
  touch_evt_t cur_evt;

  // Direction of a finished press from its displacement.
  function automatic gesture_t swipe_dir(int dx, int dy);
    int ax;
    int ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax < int'(sw_thr) && ay < int'(sw_thr)) return G_NONE;
    if (ax > ay) return (dx > 0) ? G_RIGHT : G_LEFT;
    return (dy > 0) ? G_DOWN : G_UP;
  endfunction

  // Advance the tracked touch state by one accepted beat.
  function automatic void track_touch(touch_evt_t e);
    logic [FIELD_WIDTH-1:0] was;
    swipe_t s;
    if (e.ev_type == EVT_ABS) begin
      was = last_axis;
      last_axis = e.ev_code;
      if (e.ev_code == AXIS_X) held_x = e.ev_value;
      if (was == AXIS_X && e.ev_code == AXIS_Y) begin
        pos_x = held_x;
        pos_y = e.ev_value;
        if (!org_valid) begin
          org_valid = 1'b1;
          org_x = pos_x;
          org_y = pos_y;
        end
      end
    end else if (e.ev_type == EVT_KEY && e.ev_code == KEY_TOUCH && e.ev_value == '0) begin
      s.gesture = swipe_dir(int'(pos_x) - int'(org_x), int'(pos_y) - int'(org_y));
      s.start_x = org_x;
      s.start_y = org_y;
      s.end_x = pos_x;
      s.end_y = pos_y;
      swipes_due.push_back(s);
      last_axis = NO_AXIS_CODE;
      held_x = '0;
      org_x = '0;
      org_y = '0;
      org_valid = 1'b0;
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: one beat per handshake, random gaps between beats.
  always @(posedge clk) begin
    touch_evt_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_touch(cur_evt);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (touch_q.size() > 0) begin
          nxt = touch_q.pop_front();
          cur_evt = nxt;
          in_event_type <= nxt.ev_type;
          in_event_code <= nxt.ev_code;
          in_event_value <= nxt.ev_value;
          in_valid <= 1'b1;
          send_gap = pick_gap(idle_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest owed swipe.
  always @(posedge clk) begin
    swipe_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (swipes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: g=%0d start=(%h,%h) end=(%h,%h)", out_gesture,
                     out_start_x, out_start_y, out_end_x, out_end_y);
        end else begin
          want = swipes_due.pop_front();
          if (out_gesture !== want.gesture || out_start_x !== want.start_x ||
              out_start_y !== want.start_y || out_end_x !== want.end_x ||
              out_end_y !== want.end_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected g=%0d start=(%h,%h) end=(%h,%h), got g=%0d start=(%h,%h) end=(%h,%h)",
                       want.gesture, want.start_x, want.start_y, want.end_x, want.end_y,
                       out_gesture, out_start_x, out_start_y, out_end_x, out_end_y);
          end
        end
      end
      if (hold_taken != hold_asked) begin
        hold_taken++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(idle_mode);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic void push_touch(logic [FIELD_WIDTH-1:0] t, logic [FIELD_WIDTH-1:0] c,
                                     logic [FIELD_WIDTH-1:0] v);
    touch_evt_t e;
    e.ev_type = t;
    e.ev_code = c;
    e.ev_value = v;
    touch_q.push_back(e);
  endfunction

  function automatic void push_pair(logic [FIELD_WIDTH-1:0] x, logic [FIELD_WIDTH-1:0] y);
    push_touch(EVT_ABS, AXIS_X, x);
    push_touch(EVT_ABS, AXIS_Y, y);
  endfunction

  function automatic void push_lift();
    push_touch(EVT_KEY, KEY_TOUCH, '0);
  endfunction

  // Stray beats; only the fully random kind can ever form part of a pair or a release.
  function automatic void push_noise();
    case ($urandom_range(0, 4))
      0: push_touch(16'($urandom), 16'($urandom), 16'($urandom));
      1: push_touch(EVT_KEY, KEY_TOUCH, 16'($urandom_range(1, 65535)));
      2: push_touch(EVT_KEY, 16'($urandom_range(331, 65535)), '0);
      3: push_touch(EVT_ABS, 16'($urandom_range(2, 65535)), 16'($urandom));
      default: push_touch(16'($urandom_range(4, 65535)), AXIS_X, 16'($urandom));
    endcase
  endfunction

  // Signed displacement, clustered around the current threshold.
  function automatic int pick_delta();
    int m;
    case ($urandom_range(0, 9))
      0, 1, 2: m = int'(sw_thr) + $urandom_range(0, 4) - 2;
      3, 4:    m = $urandom_range(0, int'(sw_thr));
      5, 6, 7: m = $urandom_range(0, 65535);
      8:       m = 0;
      default: m = int'(sw_thr);
    endcase
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic int clamp_end(int from, int d);
    int p;
    p = from + d;
    if (p < 0 || p > 65535) p = from - d;
    if (p < 0 || p > 65535) p = $urandom_range(0, 65535);
    return p;
  endfunction

  // Wait until nothing is queued, in flight or owed, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    while (touch_q.size() != 0 || in_valid || swipes_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(logic [FIELD_WIDTH-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sw_thr = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Whole presses with random content, plus stray and broken sequences.
  task automatic run_random(int target);
    int sent;
    int sx;
    int sy;
    int dx;
    int dy;
    int k;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) push_noise();
      sx = $urandom_range(0, 65535);
      sy = $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) sx = $urandom_range(0, 1) * 65535;
      if ($urandom_range(0, 9) == 0) sy = $urandom_range(0, 1) * 65535;
      dx = pick_delta();
      // Occasionally equal magnitudes, which must resolve vertically.
      if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
      else dy = pick_delta();
      if ($urandom_range(0, 3) == 0) push_touch(EVT_KEY, KEY_TOUCH, 16'($urandom_range(1, 65535)));
      if ($urandom_range(0, 9) != 0) begin
        push_pair(16'(sx), 16'(sy));
        sent += 2;
        k = $urandom_range(0, 2);
        repeat (k) begin
          case ($urandom_range(0, 9))
            0, 1: push_noise();
            2: push_touch(EVT_ABS, AXIS_X, 16'($urandom));
            3: push_touch(EVT_ABS, AXIS_Y, 16'($urandom));
            default: begin
              push_pair(16'($urandom), 16'($urandom));
              sent += 2;
            end
          endcase
        end
        push_pair(16'(clamp_end(sx, dx)), 16'(clamp_end(sy, dy)));
        sent += 2;
      end
      push_lift();
      sent += 1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset threshold.
    push_lift();
    push_pair(16'd100, 16'd100);
    push_pair(16'd160, 16'd100);
    push_lift();
    push_pair(16'hFFFF, 16'hFFFF);
    push_pair(16'h0000, 16'hFFC1);
    push_lift();
    push_pair(16'h8000, 16'h8000);
    // A Y after some other axis code must not form a pair.
    push_touch(EVT_ABS, 16'd5, 16'h1234);
    push_touch(EVT_ABS, AXIS_Y, 16'h0000);
    push_touch(16'hFFFF, AXIS_X, 16'h5555);
    push_touch(EVT_KEY, KEY_TOUCH, 16'h0001);
    push_touch(EVT_KEY, 16'hFFFF, 16'h0000);
    push_pair(16'h8000, 16'h8040);
    push_lift();
    push_pair(16'd500, 16'd500);
    push_pair(16'd559, 16'd441);
    push_lift();

    // Zero threshold, back-to-back traffic and a long receiver hold-off.
    set_threshold(16'd0);
    idle_mode = 0;
    hold_asked++;
    push_pair(16'h1234, 16'h4321);
    push_lift();
    push_lift();
    run_random(300);

    set_threshold(16'hFFFF);
    idle_mode = 1;
    run_random(250);

    set_threshold(16'd1);
    run_random(300);

    set_threshold(16'($urandom_range(20, 500)));
    run_random(300);

    set_threshold(THRESHOLD_RESET);
    run_random(300);

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tsd_pkg.sv
hdl/touch_swipe_detector.sv
test/tb.sv
